>>> rtl/button_click_gesture_recognizer_core_macros.svh
// Assertion macros shared by the checker of the gesture recognizer.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef BUTTON_CLICK_GESTURE_RECOGNIZER_CORE_MACROS_SVH
`define BUTTON_CLICK_GESTURE_RECOGNIZER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BCGR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BCGR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bcgr_pkg.sv
// Shared types, constants and pattern tables of the gesture recognizer.
// No dependencies.
package bcgr_pkg;

  localparam int CFG_W      = 16;
  localparam int STEP_W     = 3;
  localparam int CODE_W     = 3;
  localparam int RES_W      = CODE_W + 1;
  localparam int PAT_MAX    = 4;
  localparam int PATTERN_COUNT_DEF = 4;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd20;
  localparam logic [CFG_W-1:0] IDLE_MIN_RST = 16'd501;
  localparam logic [CFG_W-1:0] SHORT_MAX_RST = 16'd300;
  localparam logic [CFG_W-1:0] LONG_MIN_RST = 16'd600;
  localparam logic [CFG_W-1:0] LONG_MAX_RST = 16'd2000;
  localparam logic [CFG_W-1:0] AGE_CAP_RST = 16'd4000;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_DEBOUNCE  = 3'd0,
    CFG_IDLE_MIN  = 3'd1,
    CFG_SHORT_MAX = 3'd2,
    CFG_LONG_MIN  = 3'd3,
    CFG_LONG_MAX  = 3'd4,
    CFG_AGE_CAP   = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_IDLE  = 2'd0,
    KIND_SHORT = 2'd1,
    KIND_LONG  = 2'd2
  } win_kind_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] idle_min_ticks;
    logic [CFG_W-1:0] short_max_ticks;
    logic [CFG_W-1:0] long_min_ticks;
    logic [CFG_W-1:0] long_max_ticks;
    logic [CFG_W-1:0] age_cap_ticks;
  } cfg_t;

  // Number of steps of each pattern.
  function automatic logic [STEP_W-1:0] pat_len(input logic [1:0] p);
    logic [STEP_W-1:0] len;
    case (p)
      2'd0:    len = 3'd3;
      2'd1:    len = 3'd5;
      2'd2:    len = 3'd3;
      default: len = 3'd5;
    endcase
    return len;
  endfunction

  // Window kind of each step of each pattern.
  function automatic win_kind_t pat_kind(input logic [1:0] p, input logic [STEP_W-1:0] s);
    win_kind_t k;
    k = KIND_IDLE;
    case (p)
      2'd0: if (s == 3'd1) k = KIND_SHORT;
      2'd1: if (s == 3'd1 || s == 3'd2 || s == 3'd3) k = KIND_SHORT;
      2'd2: if (s == 3'd1) k = KIND_LONG;
      default: begin
        if (s == 3'd1) k = KIND_LONG;
        else if (s == 3'd2 || s == 3'd3) k = KIND_SHORT;
      end
    endcase
    return k;
  endfunction

endpackage

>>> rtl/button_click_gesture_recognizer_core.sv
// Top level of the button click gesture recognizer.
// Depends on bcgr_pkg, bcgr_debounce, bcgr_gesture and bcgr_outbuf.
//
// Usage:
//  - in_* stream: one transaction per timer tick, in_tdata[0] is the raw
//    pressed level. Every accepted tick yields exactly one result.
//  - out_* stream: out_tdata[2:0] is the gesture code (0 none, 1 single,
//    2 double, 3 long, 4 long then short), out_tdata[3] the debounced level.
//  - cfg_* port: write cfg_wdata into register cfg_index when cfg_we is high;
//    write only while no result is pending. Unknown indexes are ignored.
//  - Result: the result of a tick is registered in the output register, or in the
//    skid entry while that one is held. Throughput: one tick per cycle while in_tready
//    is high; each tick is evaluated in one pass from the state registers.
//  - Stall: an output register plus a skid entry absorb one extra result;
//    in_tready drops only when both hold results, and rises again the cycle
//    after the receiver takes one.
//  - Reset (rst_n low, synchronous): config returns to its defaults
//    (20, 501, 300, 600, 2000, 4000), debounce, edge age and all pattern
//    matchers clear, and the output buffer empties.
module button_click_gesture_recognizer_core #(
  parameter int PATTERN_COUNT = bcgr_pkg::PATTERN_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] raw_pressed, [7:1] zero
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [2:0] gesture_code, [3] debounced_level, [7:4] zero
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  bcgr_pkg::cfg_t                    cfg_r;
  logic                              in_accept;
  logic                              level;
  logic [bcgr_pkg::CODE_W-1:0]       code;
  logic [bcgr_pkg::RES_W-1:0]        res_data;

  assign in_accept = in_tvalid && in_tready;

  // Configuration registers: hold defaults after reset, update on write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks  <= bcgr_pkg::DEBOUNCE_RST;
      cfg_r.idle_min_ticks  <= bcgr_pkg::IDLE_MIN_RST;
      cfg_r.short_max_ticks <= bcgr_pkg::SHORT_MAX_RST;
      cfg_r.long_min_ticks  <= bcgr_pkg::LONG_MIN_RST;
      cfg_r.long_max_ticks  <= bcgr_pkg::LONG_MAX_RST;
      cfg_r.age_cap_ticks   <= bcgr_pkg::AGE_CAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bcgr_pkg::CFG_DEBOUNCE:  cfg_r.debounce_ticks  <= cfg_wdata;
        bcgr_pkg::CFG_IDLE_MIN:  cfg_r.idle_min_ticks  <= cfg_wdata;
        bcgr_pkg::CFG_SHORT_MAX: cfg_r.short_max_ticks <= cfg_wdata;
        bcgr_pkg::CFG_LONG_MIN:  cfg_r.long_min_ticks  <= cfg_wdata;
        bcgr_pkg::CFG_LONG_MAX:  cfg_r.long_max_ticks  <= cfg_wdata;
        bcgr_pkg::CFG_AGE_CAP:   cfg_r.age_cap_ticks   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Debounce the raw level; the new stable level feeds the matchers directly.
  bcgr_debounce u_debounce (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .raw        (in_tdata[0]),
    .cfg        (cfg_r),
    .stable_nxt (level)
  );

  // Track edge age and advance the pattern matchers.
  bcgr_gesture #(
    .PATTERN_COUNT (PATTERN_COUNT)
  ) u_gesture (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .level  (level),
    .cfg    (cfg_r),
    .code   (code)
  );

  assign res_data = {level, code};

  // Register the result; skid entry keeps input flowing during a stall.
  bcgr_outbuf #(
    .DATA_W (bcgr_pkg::RES_W)
  ) u_outbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_accept),
    .wr_data  (res_data),
    .wr_ready (in_tready),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_data  (out_tdata[bcgr_pkg::RES_W-1:0])
  );

  assign out_tdata[7:bcgr_pkg::RES_W] = '0;

endmodule

>>> rtl/bcgr_debounce.sv
// Debounce stage of the gesture recognizer: settling counter and stable level.
// Depends on bcgr_pkg.
module bcgr_debounce (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic          raw,
  input  bcgr_pkg::cfg_t cfg,
  output logic          stable_nxt
);

  logic                        raw_last_r, raw_last_nxt;
  logic                        settling_r, settling_nxt;
  logic                        stable_r;
  logic [bcgr_pkg::CFG_W-1:0]  settle_count_r, settle_count_nxt;
  logic [bcgr_pkg::CFG_W-1:0]  cnt_inc;

  always_comb begin
    cnt_inc          = (settle_count_r == '1) ? settle_count_r : settle_count_r + 1'b1;
    raw_last_nxt     = raw;
    settling_nxt     = settling_r;
    settle_count_nxt = settle_count_r;
    stable_nxt       = stable_r;
    if (raw != raw_last_r) begin
      // restart settling on any raw change
      settle_count_nxt = '0;
      settling_nxt     = 1'b1;
    end else if (settling_r) begin
      settle_count_nxt = cnt_inc;
      if (cnt_inc >= cfg.debounce_ticks) begin
        settling_nxt = 1'b0;
        stable_nxt   = raw;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_last_r     <= 1'b0;
      settling_r     <= 1'b0;
      stable_r       <= 1'b0;
      settle_count_r <= '0;
    end else if (accept) begin
      raw_last_r     <= raw_last_nxt;
      settling_r     <= settling_nxt;
      stable_r       <= stable_nxt;
      settle_count_r <= settle_count_nxt;
    end
  end

endmodule

>>> rtl/bcgr_gesture.sv
// Edge age tracking and interval-pattern matchers of the gesture recognizer.
// Depends on bcgr_pkg.
module bcgr_gesture #(
  parameter int PATTERN_COUNT = bcgr_pkg::PATTERN_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic                         level,
  input  bcgr_pkg::cfg_t               cfg,
  output logic [bcgr_pkg::CODE_W-1:0]  code
);

  localparam int SW = bcgr_pkg::STEP_W;
  localparam int CW = bcgr_pkg::CFG_W;

  logic                 edge_level_last_r;
  logic [CW-1:0]        edge_age_r, edge_age_nxt;
  logic [CW:0]          age_sum;
  logic [CW-1:0]        dur;
  logic                 is_edge;
  logic [SW-1:0]        step_r   [PATTERN_COUNT];
  logic [SW-1:0]        step_nxt [PATTERN_COUNT];
  logic [PATTERN_COUNT-1:0] fire;

  function automatic logic fits(input bcgr_pkg::win_kind_t k, input logic [CW-1:0] d,
                                input bcgr_pkg::cfg_t c);
    logic ok;
    case (k)
      bcgr_pkg::KIND_IDLE:  ok = (d >= c.idle_min_ticks);
      bcgr_pkg::KIND_SHORT: ok = (d <= c.short_max_ticks);
      bcgr_pkg::KIND_LONG:  ok = (d >= c.long_min_ticks) && (d <= c.long_max_ticks);
      default:              ok = 1'b0;
    endcase
    return ok;
  endfunction

  always_comb begin
    age_sum = {1'b0, edge_age_r} + 1'b1;
    dur     = age_sum[CW] ? '1 : age_sum[CW-1:0];
    is_edge = (level != edge_level_last_r);
    if (is_edge)                    edge_age_nxt = '0;
    else if (dur > cfg.age_cap_ticks) edge_age_nxt = cfg.age_cap_ticks;
    else                            edge_age_nxt = dur;
  end

  for (genvar p = 0; p < PATTERN_COUNT; p++) begin : g_pat
    localparam logic [1:0] PI = 2'(p);
    logic [SW-1:0]        step_eff;
    logic [SW-1:0]        step_inc;
    bcgr_pkg::win_kind_t  kind;

    always_comb begin
      step_eff    = (step_r[p] >= bcgr_pkg::pat_len(PI)) ? '0 : step_r[p];
      kind        = bcgr_pkg::pat_kind(PI, step_eff);
      step_inc    = step_eff + 1'b1;
      step_nxt[p] = step_eff;
      fire[p]     = 1'b0;
      if (is_edge) begin
        if (level || step_eff != '0) begin
          if (fits(kind, dur, cfg)) begin
            if (step_inc >= bcgr_pkg::pat_len(PI)) begin
              // completed: report and count this press as a fresh first step
              fire[p]     = 1'b1;
              step_nxt[p] = SW'(1);
            end else begin
              step_nxt[p] = step_inc;
            end
          end else begin
            step_nxt[p] = '0;
          end
        end
      end else if (!level && step_eff != '0 && kind == bcgr_pkg::KIND_IDLE &&
                   dur >= cfg.idle_min_ticks) begin
        fire[p]     = 1'b1;
        step_nxt[p] = '0;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        step_r[p] <= '0;
      end else if (accept) begin
        step_r[p] <= step_nxt[p];
      end
    end
  end

  // highest-numbered firing pattern wins
  always_comb begin
    code = '0;
    for (int i = 0; i < PATTERN_COUNT; i++) begin
      if (fire[i]) code = bcgr_pkg::CODE_W'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_level_last_r <= 1'b0;
      edge_age_r        <= '0;
    end else if (accept) begin
      edge_level_last_r <= level;
      edge_age_r        <= edge_age_nxt;
    end
  end

endmodule

>>> rtl/bcgr_outbuf.sv
// Two-entry output register with skid stage for the result channel.
// Depends on nothing but its parameter.
module bcgr_outbuf #(
  parameter int DATA_W = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  input  logic [DATA_W-1:0] wr_data,
  output logic              wr_ready,
  output logic              rd_valid,
  input  logic              rd_ready,
  output logic [DATA_W-1:0] rd_data
);

  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  logic              skid_valid_r;
  logic [DATA_W-1:0] skid_data_r;
  logic              rd_fire;

  assign wr_ready = !skid_valid_r;
  assign rd_valid = out_valid_r;
  assign rd_data  = out_data_r;
  assign rd_fire  = out_valid_r && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (rd_fire) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= wr_valid;
      end
    end else if (wr_valid) begin
      if (out_valid_r) skid_valid_r <= 1'b1;
      else             out_valid_r  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_fire) begin
      if (skid_valid_r) out_data_r <= skid_data_r;
      else if (wr_valid) out_data_r <= wr_data;
    end else if (wr_valid) begin
      if (out_valid_r) skid_data_r <= wr_data;
      else             out_data_r  <= wr_data;
    end
  end

endmodule

>>> rtl/bcgr_checker.sv
// Port-level checker for the gesture recognizer, bound to the top level.
// Depends on button_click_gesture_recognizer_core_macros.svh.
`include "button_click_gesture_recognizer_core_macros.svh"

module bcgr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // every accepted tick leaves a result waiting in the next cycle
  `BCGR_ASSERT_NEXT(a_accept_gives_result, in_tvalid && in_tready, out_tvalid, "tick lost")

  // input is refused only while results are waiting
  `BCGR_ASSERT_SAME(a_stall_needs_result, !in_tready, out_tvalid, "refused with empty output")

  // gesture code stays within its five meanings
  `BCGR_ASSERT_SAME(a_code_range, out_tvalid,
    !(out_tdata[2] && (out_tdata[1] || out_tdata[0])) && out_tdata[7:4] == 4'd0,
    "bad gesture code")

  // a stalled result holds
  `BCGR_ASSERT_NEXT(a_hold_on_stall, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata), "result changed under stall")

endmodule

bind button_click_gesture_recognizer_core bcgr_checker u_bcgr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
